[hdl/pnse_pkg.sv]
`timescale 1ns / 1ps

package pnse_pkg;

    // Line store geometry.
    localparam int MAX_ROW_BYTES = 256;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);

    // Configuration register widths.
    localparam int ROW_BYTES_W  = 9;
    localparam int FRAME_ROWS_W = 10;
    localparam int THRESHOLD_W  = 7;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 2;

    // Width that holds both the clamped row length and a column plus one.
    localparam int LEN_W = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RST  = 9'd160;
    localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = 10'd240;
    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RST  = 7'd11;

    // Largest edge value a nibble can carry.
    localparam logic [3:0] EDGE_MAX = 4'hF;

    typedef struct packed {
        logic [7:0] pixel_pair;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0] edge_pair;
        logic       frame_end;
    } out_word_t;

endpackage

[hdl/packed_nibble_sobel_edge.sv]
`timescale 1ns / 1ps

// Streaming 3x3 edge detector on 4-bit grey pixels packed two to a byte.
//
// Input channel (in_valid / in_ready / in_data): one packed pixel word per
// cycle unless stalled; high nibble is the left pixel. frame_start marks the
// first word of a frame. After the last image row the host sends one flush
// row, whose pixels are read as zero. Output channel (out_valid / out_ready /
// out_data): one result word per input word of rows 1 through the flush row;
// row 0 gives no result. frame_end is set on the last word of the flush row.
//
// A word is held in the read stage and its result in the output register.
// Throughput is one word per cycle while the receiver does not stall: the
// line store is read when a word is accepted and written back when the read
// stage advances, so it does at most one read and one write each cycle.
//
// Reset clears the counters and restores the register defaults; line store
// contents are undefined until a full row has been written. When the receiver
// stalls, the output register and read stage both hold, and in_ready drops
// once the read stage is occupied and cannot advance. The user must write
// configuration (cfg_we / cfg_index / cfg_data) only while idle; not enforced.

module packed_nibble_sobel_edge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pnse_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pnse_pkg::out_word_t                 out_data,
    input  logic                                cfg_we,
    input  logic [pnse_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pnse_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [pnse_pkg::ROW_BYTES_W-1:0]  row_bytes_reg;
    logic [pnse_pkg::FRAME_ROWS_W-1:0] frame_rows_reg;
    logic [pnse_pkg::THRESHOLD_W-1:0]  edge_threshold_reg;

    // Raster position of the next word.
    logic [pnse_pkg::COL_W-1:0]        col_reg, col_next;
    logic [pnse_pkg::FRAME_ROWS_W-1:0] row_reg, row_next;

    // Line store: each entry holds {upper row byte, middle row byte}.
    logic [15:0] line_mem [pnse_pkg::MAX_ROW_BYTES];
    logic [15:0] mem_rd_reg;

    // Read stage: the word whose line store read is in flight.
    logic                       s1_valid_reg;
    logic [pnse_pkg::COL_W-1:0] s1_col_reg;
    logic [7:0]                 s1_cur_reg;
    logic                       s1_emit_reg;
    logic                       s1_end_reg;
    logic                       s1_top_zero_reg;
    logic                       s1_col0_reg;

    // Last write into the line store, forwarded to a read at the same column.
    logic                       fwd_valid_reg;
    logic [pnse_pkg::COL_W-1:0] fwd_col_reg;
    logic [15:0]                fwd_data_reg;

    // Left column bytes of the top and middle rows. The bottom-row left byte
    // never enters the sum and is not kept.
    logic [15:0] left_bytes_reg;

    // Output register.
    logic                out_valid_reg;
    pnse_pkg::out_word_t out_data_reg;

    // Stage 0 signals.
    logic                              accept;
    logic [pnse_pkg::COL_W-1:0]        col_cur;
    logic [pnse_pkg::FRAME_ROWS_W-1:0] row_cur;
    logic [pnse_pkg::LEN_W-1:0]        len_eff;
    logic [pnse_pkg::FRAME_ROWS_W-1:0] rows_eff;
    logic [pnse_pkg::LEN_W-1:0]        col_plus1;
    logic                              is_flush;
    logic                              is_last;

    // Stage 1 signals.
    logic        s1_fire;
    logic [15:0] rd_data;
    logic [7:0]  up_byte;
    logic [7:0]  mid_byte;
    logic [7:0]  lt_byte;
    logic [7:0]  lm_byte;
    logic [6:0]  pos_sum;
    logic [6:0]  neg_sum;
    logic signed [7:0] edge_sum;
    logic [3:0]  edge_val;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg      <= pnse_pkg::ROW_BYTES_RST;
            frame_rows_reg     <= pnse_pkg::FRAME_ROWS_RST;
            edge_threshold_reg <= pnse_pkg::THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pnse_pkg::CFG_ROW_BYTES:
                    row_bytes_reg <= cfg_data[pnse_pkg::ROW_BYTES_W-1:0];
                pnse_pkg::CFG_FRAME_ROWS:
                    frame_rows_reg <= cfg_data[pnse_pkg::FRAME_ROWS_W-1:0];
                pnse_pkg::CFG_EDGE_THRESHOLD:
                    edge_threshold_reg <= cfg_data[pnse_pkg::THRESHOLD_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position tracking and line store read address.
    // ------------------------------------------------------------------
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // A row length of zero behaves as one, and longer rows are clamped
        // to the line store depth.
        if (row_bytes_reg == '0)
            len_eff = pnse_pkg::LEN_W'(1);
        else if (pnse_pkg::LEN_W'(row_bytes_reg) > pnse_pkg::LEN_W'(pnse_pkg::MAX_ROW_BYTES))
            len_eff = pnse_pkg::LEN_W'(pnse_pkg::MAX_ROW_BYTES);
        else
            len_eff = pnse_pkg::LEN_W'(row_bytes_reg);

        if (frame_rows_reg == '0)
            rows_eff = pnse_pkg::FRAME_ROWS_W'(1);
        else
            rows_eff = frame_rows_reg;

        if (in_data.frame_start)
        begin
            col_cur = '0;
            row_cur = '0;
        end
        else
        begin
            col_cur = col_reg;
            row_cur = row_reg;
        end

        col_plus1 = pnse_pkg::LEN_W'(col_cur) + pnse_pkg::LEN_W'(1);
        is_flush  = (row_cur >= rows_eff);
        is_last   = (col_plus1 >= len_eff);

        // The row after the flush row starts a new frame on its own.
        if (is_last)
        begin
            col_next = '0;
            if (is_flush)
                row_next = '0;
            else
                row_next = row_cur + pnse_pkg::FRAME_ROWS_W'(1);
        end
        else
        begin
            col_next = col_plus1[pnse_pkg::COL_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col_cur;
            s1_cur_reg      <= is_flush ? 8'h00 : in_data.pixel_pair;
            s1_emit_reg     <= (row_cur != '0);
            s1_end_reg      <= is_flush && is_last;
            s1_top_zero_reg <= (row_cur < pnse_pkg::FRAME_ROWS_W'(2));
            s1_col0_reg     <= (col_cur == '0);
        end
    end

    // Line store: read on acceptance, written when the read stage advances.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_col_reg] <= {mid_byte, s1_cur_reg};
        if (accept)
            mem_rd_reg <= line_mem[col_cur];
    end

    // ------------------------------------------------------------------
    // Stage 1: window assembly, kernel sum and write-back.
    // ------------------------------------------------------------------
    always_comb
    begin
        // A read issued in the same cycle as a write to that column returns
        // stale data; the forwarding register always holds the newest write.
        if (fwd_valid_reg && (fwd_col_reg == s1_col_reg))
            rd_data = fwd_data_reg;
        else
            rd_data = mem_rd_reg;

        mid_byte = rd_data[7:0];
        up_byte  = s1_top_zero_reg ? 8'h00 : rd_data[15:8];
        lt_byte  = s1_col0_reg ? 8'h00 : left_bytes_reg[15:8];
        lm_byte  = s1_col0_reg ? 8'h00 : left_bytes_reg[7:0];

        pos_sum = 7'(mid_byte[3:0]) + 7'(s1_cur_reg[7:4]) + 7'(s1_cur_reg[3:0]);
        neg_sum = 7'(lt_byte[3:0]) + 7'(up_byte[7:4]) + 7'(lm_byte[3:0]);
        edge_sum = $signed({pos_sum, 1'b0}) - $signed({neg_sum, 1'b0});

        if (edge_sum < $signed({1'b0, edge_threshold_reg}))
            edge_val = 4'h0;
        else if (edge_sum > $signed(8'(pnse_pkg::EDGE_MAX)))
            edge_val = pnse_pkg::EDGE_MAX;
        else
            edge_val = edge_sum[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (s1_fire)
            fwd_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            fwd_col_reg    <= s1_col_reg;
            fwd_data_reg   <= {mid_byte, s1_cur_reg};
            left_bytes_reg <= {up_byte, mid_byte};
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= s1_emit_reg;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            out_data_reg.edge_pair <= {edge_val, edge_val};
            out_data_reg.frame_end <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A stalled read stage keeps its word and column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=>
            (s1_valid_reg && $stable(s1_col_reg)))
        else $error("read stage lost its word during an output stall");

    // No word is taken while the read stage is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(s1_valid_reg && out_valid_reg && !out_ready))
        else $error("word accepted while the read stage was blocked");

    // Every write-back is captured for forwarding.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (fwd_valid_reg && (fwd_col_reg == $past(s1_col_reg))))
        else $error("forwarding register missed a line store write");

    // Both nibbles of a result carry the same edge value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.edge_pair[7:4] == out_data.edge_pair[3:0]))
        else $error("result nibbles differ");

endmodule

[tb/packed_nibble_sobel_edge_test.sv]
`timescale 1ns / 1ps

// Self-checking testbench for the packed nibble edge detector. Pixel words go
// in on a valid/ready channel, edge words come out on another, and a local
// model of the block predicts every result word as soon as its pixel word is
// accepted. Results are checked in order, field by field, as they leave.

module packed_nibble_sobel_edge_test;

    // Generous bound on the whole run, meant only to catch a block that hangs.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to let pass once nothing is expected any more. Words of row 0
    // produce no result, so the block may still be busy with one of them.
    localparam int SETTLE_CYCLES = 8;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    pnse_pkg::in_word_t               in_data;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    pnse_pkg::out_word_t              out_data;
    logic                             cfg_we;
    logic [pnse_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pnse_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Percent of cycles in which the sender holds back a word and the
    // receiver refuses one. The main sequence changes them between phases.
    int send_gap_pct;
    int recv_stall_pct;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Edge words predicted but not yet seen on the output, oldest first.
    pnse_pkg::out_word_t expected_edges[$];

    // Model copy of the configuration registers, starting at reset values.
    logic [pnse_pkg::ROW_BYTES_W-1:0]  model_row_bytes  = pnse_pkg::ROW_BYTES_RST;
    logic [pnse_pkg::FRAME_ROWS_W-1:0] model_frame_rows = pnse_pkg::FRAME_ROWS_RST;
    logic [pnse_pkg::THRESHOLD_W-1:0]  model_threshold  = pnse_pkg::THRESHOLD_RST;

    // Model line stores: the row two above and the row just above the one
    // being received. Entries stay unknown until a row writes them.
    logic [7:0] older_row [pnse_pkg::MAX_ROW_BYTES];
    logic [7:0] newer_row [pnse_pkg::MAX_ROW_BYTES];

    // Bytes of the previous column in the top, middle and bottom rows.
    logic [23:0] left_col = '0;
    int unsigned col_pos  = 0;
    int unsigned row_pos  = 0;

    packed_nibble_sobel_edge dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Row length as the block uses it: zero acts as one, and anything past the
    // line store size acts as the line store size.
    function automatic int unsigned row_length();
        if (model_row_bytes == 0)
            return 1;
        if (model_row_bytes > pnse_pkg::MAX_ROW_BYTES)
            return pnse_pkg::MAX_ROW_BYTES;
        return 32'(model_row_bytes);
    endfunction

    // Frame height as the block uses it: zero acts as one.
    function automatic int unsigned frame_height();
        if (model_frame_rows == 0)
            return 1;
        return 32'(model_frame_rows);
    endfunction

    // Advances the model by one accepted pixel word and queues the edge word
    // it causes, if any.
    function automatic void predict_edge(pnse_pkg::in_word_t w);
        int unsigned                len;
        logic [pnse_pkg::COL_W-1:0] col;
        logic                       flush;
        logic                       last;
        logic [7:0]                 cur;
        logic [7:0]                 mid;
        logic [7:0]                 up;
        logic [7:0]                 lt;
        logic [7:0]                 lm;
        int                         pos_terms;
        int                         neg_terms;
        int                         sum;
        logic [3:0]                 mag;
        pnse_pkg::out_word_t        r;

        len = row_length();
        if (w.frame_start)
        begin
            col_pos  = 0;
            row_pos  = 0;
            left_col = '0;
        end

        col   = pnse_pkg::COL_W'(col_pos % pnse_pkg::MAX_ROW_BYTES);
        flush = (row_pos >= frame_height());
        // The flush row reads as zero, and so does the top row while the
        // window still hangs over the top edge of the image.
        cur = flush ? 8'h00 : w.pixel_pair;
        mid = newer_row[col];
        up  = (row_pos < 2) ? 8'h00 : older_row[col];
        // At the left edge the column to the left is padding.
        lt = (col == 0) ? 8'h00 : left_col[23:16];
        lm = (col == 0) ? 8'h00 : left_col[15:8];

        older_row[col] = newer_row[col];
        newer_row[col] = cur;
        left_col       = {up, mid, cur};
        last           = ((32'(col) + 1) >= len);

        // Row 0 only fills the line stores; every word of a later row gives one word.
        if (row_pos != 0)
        begin
            pos_terms = int'(mid[3:0]) + int'(cur[7:4]) + int'(cur[3:0]);
            neg_terms = int'(lt[3:0]) + int'(up[7:4]) + int'(lm[3:0]);
            sum       = 2 * pos_terms - 2 * neg_terms;
            if (sum < int'(model_threshold))
                sum = 0;
            if (sum > int'(pnse_pkg::EDGE_MAX))
                sum = int'(pnse_pkg::EDGE_MAX);
            mag         = sum[3:0];
            r.edge_pair = {mag, mag};
            r.frame_end = flush && last;
            expected_edges.push_back(r);
        end

        if (last)
        begin
            col_pos = 0;
            row_pos = flush ? 0 : ((row_pos + 1) & 10'h3FF);
        end
        else
        begin
            col_pos = 32'(col) + 1;
        end
    endfunction

    // Offers one pixel word, after a random gap, and returns at the clock
    // edge that accepts it. Acceptance is decided at the falling edge, where
    // every signal of the channel is stable.
    task automatic send_pair(input logic [7:0] pix, input logic fs);
        int                 gap;
        pnse_pkg::in_word_t w;

        gap = 0;
        while ($urandom_range(99) < send_gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.pixel_pair = pix;
        w.frame_start = fs;
        in_valid <= 1'b1;
        in_data  <= w;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predict_edge(w);
    endtask

    // Stops offering words and waits until the block has nothing in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the enable stays high so writes can follow back to
    // back, and the caller lowers it after the last one.
    task automatic write_reg(input logic [pnse_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pnse_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            pnse_pkg::CFG_ROW_BYTES:
                model_row_bytes = value[pnse_pkg::ROW_BYTES_W-1:0];
            pnse_pkg::CFG_FRAME_ROWS:
                model_frame_rows = value[pnse_pkg::FRAME_ROWS_W-1:0];
            pnse_pkg::CFG_EDGE_THRESHOLD:
                model_threshold = value[pnse_pkg::THRESHOLD_W-1:0];
            default: ;
        endcase
    endtask

    // Drains the block and then writes all three registers.
    task automatic configure(input logic [pnse_pkg::ROW_BYTES_W-1:0] rb,
                             input logic [pnse_pkg::FRAME_ROWS_W-1:0] fr,
                             input logic [pnse_pkg::THRESHOLD_W-1:0] th);
        wait_idle();
        write_reg(pnse_pkg::CFG_ROW_BYTES, pnse_pkg::CFG_DATA_W'(rb));
        write_reg(pnse_pkg::CFG_FRAME_ROWS, pnse_pkg::CFG_DATA_W'(fr));
        write_reg(pnse_pkg::CFG_EDGE_THRESHOLD, pnse_pkg::CFG_DATA_W'(th));
        cfg_we <= 1'b0;
    endtask

    // A tiny frame under the reset threshold, with the nibble extremes.
    // The threshold register is left alone so its reset value is used.
    task automatic test_default_threshold();
        write_reg(pnse_pkg::CFG_ROW_BYTES, pnse_pkg::CFG_DATA_W'(2));
        write_reg(pnse_pkg::CFG_FRAME_ROWS, pnse_pkg::CFG_DATA_W'(2));
        cfg_we <= 1'b0;
        send_pair(8'h0F, 1'b1);
        send_pair(8'hF0, 1'b0);
        send_pair(8'hFF, 1'b0);
        send_pair(8'h00, 1'b0);
        // Flush row: the pixel bits must be ignored.
        send_pair(8'hFF, 1'b0);
        send_pair(8'hFF, 1'b0);
    endtask

    // Zero row length and zero frame height both act as one, and a frame
    // that follows the flush row without a frame start begins on its own.
    task automatic test_clamped_sizes();
        configure(9'd0, 10'd0, 7'd0);
        send_pair(8'hF0, 1'b1);
        send_pair(8'h0F, 1'b0);
        send_pair(8'hFF, 1'b0);
        send_pair(8'h00, 1'b0);
    endtask

    // Register changes in the middle of a frame, made while the block idles.
    task automatic test_register_changes_mid_frame();
        int i;

        configure(9'd3, 10'd4, 7'd1);
        // Rows 0 and 1, then two words of row 2.
        for (i = 0; i < 8; i++)
            send_pair(8'($urandom), i == 0);
        // Column 2 is now past the row length, so this word ends row 2.
        configure(9'd1, 10'd4, 7'd1);
        send_pair(8'hA5, 1'b0);
        send_pair(8'h5A, 1'b0);
        // Row 4 is now past the frame height and becomes the flush row.
        configure(9'd1, 10'd3, 7'd1);
        send_pair(8'hC3, 1'b0);
    endtask

    // A frame start in the middle of a frame throws the frame away.
    task automatic test_frame_restart();
        configure(9'd1, 10'd2, 7'd0);
        send_pair(8'h12, 1'b1);
        send_pair(8'h34, 1'b0);
        send_pair(8'h56, 1'b1);
        send_pair(8'h78, 1'b0);
        send_pair(8'h9A, 1'b0);
    endtask

    // Random frames with random settings. Most frames are complete; some are
    // cut short, some carry a stray frame start, and some start without one.
    task automatic test_random_frames(input int word_goal);
        int                                sent;
        int                                total;
        int                                i;
        int                                pick;
        logic                              fs;
        logic [pnse_pkg::ROW_BYTES_W-1:0]  rb;
        logic [pnse_pkg::FRAME_ROWS_W-1:0] fr;
        logic [pnse_pkg::THRESHOLD_W-1:0]  th;

        sent = 0;
        while (sent < word_goal)
        begin
            if (sent == 0 || $urandom_range(1) == 0)
            begin
                pick = $urandom_range(99);
                rb   = (pick < 5) ? 9'd0 : 9'($urandom_range(1, 12));
                pick = $urandom_range(99);
                fr   = (pick < 5) ? 10'd0 : (pick < 12) ? 10'd1 : 10'($urandom_range(2, 6));
                pick = $urandom_range(99);
                th   = (pick < 10) ? 7'd0 : (pick < 16) ? 7'd127 : 7'($urandom_range(1, 24));
                configure(rb, fr, th);
            end
            total = int'((frame_height() + 1) * row_length());
            if ($urandom_range(9) == 0)
                total = $urandom_range(1, total);
            for (i = 0; i < total; i++)
            begin
                // Skipping the frame start is only safe at the top of a frame.
                if (i == 0)
                    fs = !(row_pos == 0 && col_pos == 0 && $urandom_range(3) == 0);
                else
                    fs = ($urandom_range(199) == 0);
                send_pair(8'($urandom), fs);
            end
            sent += total;
        end
    endtask

    // One frame at the widest row, with a row length past the line store
    // size so that the clamp is used as well. Row 0 fills the line store and
    // the flush row gives the results.
    task automatic test_widest_row();
        int i;

        configure(9'h1FF, 10'd1, 7'd6);
        for (i = 0; i < 2 * pnse_pkg::MAX_ROW_BYTES; i++)
            send_pair(8'($urandom), i == 0);
    endtask

    // The receiver refuses words at random, at its own rate.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every word accepted on the output is checked against the oldest
    // prediction. The falling edge sees the handshake that the next rising
    // edge completes.
    always @(negedge clk)
    begin
        pnse_pkg::out_word_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (expected_edges.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h/%b",
                         $time, out_data.edge_pair, out_data.frame_end);
                mismatch_count++;
            end
            else
            begin
                want = expected_edges.pop_front();
                if (out_data.edge_pair !== want.edge_pair)
                begin
                    $display("%0t: edge_pair expected %h actual %h",
                             $time, want.edge_pair, out_data.edge_pair);
                    mismatch_count++;
                end
                if (out_data.frame_end !== want.frame_end)
                begin
                    $display("%0t: frame_end expected %b actual %b",
                             $time, want.frame_end, out_data.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= pnse_pkg::CFG_ROW_BYTES;
        cfg_data  <= '0;

        // First phase: the sender gaps now and then, the receiver stalls a lot.
        send_gap_pct   = 27;
        recv_stall_pct = 66;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_default_threshold();
        test_clamped_sizes();
        test_register_changes_mid_frame();
        test_frame_restart();
        test_random_frames(50);

        // Second phase: the roles swap.
        send_gap_pct   = 66;
        recv_stall_pct = 27;
        test_random_frames(50);

        // Last phase: both sides run flat out.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_frames(50);
        test_widest_row();

        wait_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
